// ----- rtl/interval_sort_overlap_filter_top_macros.svh -----
// ============================================================================
// interval_sort_overlap_filter_top_macros.svh
// Assertion helpers shared by the interval sort / overlap filter RTL.
// ============================================================================
`ifndef INTERVAL_SORT_OVERLAP_FILTER_TOP_MACROS_SVH
`define INTERVAL_SORT_OVERLAP_FILTER_TOP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define ISOF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset.
`define ISOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/isof_pkg.sv -----
// ============================================================================
// isof_pkg
// Shared types, sizes and helpers for the interval sort / overlap filter.
// ============================================================================
package isof_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 11;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
    } t_in_item;

    typedef struct packed {
        logic [4:0] out_start_hour;
        logic [5:0] out_start_minute;
        logic [4:0] out_end_hour;
        logic [5:0] out_end_minute;
        logic       removed;
        logic       overflowed;
        logic       last;
    } t_out_item;

    // One table entry.
    typedef struct packed {
        logic [4:0] sh;
        logic [5:0] sm;
        logic [4:0] eh;
        logic [5:0] em;
    } t_ivl;

    typedef enum logic [1:0] {
        CMP_GT  = 2'b01,   // start of a later than start of b
        CMP_OVL = 2'b10    // a and b overlap
    } t_cmp_op;

    typedef struct packed {
        t_cmp_op op;
        t_ivl    a;
        t_ivl    b;
    } t_cmp_req;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        t_ivl             wr_data;
    } t_tbl_req;

    typedef struct packed {
        logic vld;
        t_ivl ivl;
        logic removed;
        logic overflowed;
        logic last;
    } t_emit;

    // Hour above minute orders by hour, then minute.
    function automatic logic [KEY_W-1:0] start_key(input t_ivl e);
        start_key = {e.sh, e.sm};
    endfunction

    function automatic logic [KEY_W-1:0] end_key(input t_ivl e);
        end_key = {e.eh, e.em};
    endfunction

endpackage

// ----- rtl/isof_table.sv -----
// ============================================================================
// isof_table
// Interval storage: one write port, one read port with registered data.
// ============================================================================
module isof_table
    import isof_pkg::*;
(
    input  logic     i_clk,
    input  t_tbl_req i_req,
    output t_ivl     o_rd_data
);

    t_ivl r_mem [MAX_ENTRIES];
    t_ivl r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/isof_cmp.sv -----
// ============================================================================
// isof_cmp
// Shared time compare unit: start order for insert, overlap for resolve.
// ============================================================================
module isof_cmp
    import isof_pkg::*;
(
    input  t_cmp_req i_req,
    output logic     o_hit
);

    logic [KEY_W-1:0] as_k, ae_k, bs_k, be_k;

    always_comb begin
        as_k = start_key(i_req.a);
        ae_k = end_key(i_req.a);
        bs_k = start_key(i_req.b);
        be_k = end_key(i_req.b);
        unique case (i_req.op)
            CMP_GT:  o_hit = as_k > bs_k;
            CMP_OVL: o_hit = (as_k <= bs_k && bs_k < ae_k) ||
                             (bs_k <= as_k && as_k < be_k);
            default: o_hit = 1'b0;
        endcase
    end

endmodule

// ----- rtl/isof_ctrl.sv -----
// ============================================================================
// isof_ctrl
// Sequencer: sorted insert by shifting later entries up, greedy overlap walk, emit.
// ============================================================================
`include "interval_sort_overlap_filter_top_macros.svh"

module isof_ctrl
    import isof_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    input  logic     i_out_free,
    output t_emit    o_emit,
    output t_tbl_req o_tbl,
    input  t_ivl     i_rd_data,
    output t_cmp_req o_cmp,
    input  logic     i_cmp_hit
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_INS_RD    = 9'b000000010,
        S_INS_CMP   = 9'b000000100,
        S_RES_OUTER = 9'b000001000,
        S_RES_LOADA = 9'b000010000,
        S_RES_JRD   = 9'b000100000,
        S_RES_JCMP  = 9'b001000000,
        S_KEEP_RD   = 9'b010000000,
        S_KEEP_EMIT = 9'b100000000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0]       r_i, n_i;
    logic [CNT_W-1:0]       r_j, n_j;
    logic [CNT_W-1:0]       r_pos, n_pos;
    logic [MAX_ENTRIES-1:0] r_marks, n_marks;
    logic                   r_ovf, n_ovf;
    t_ivl                   r_new, n_new;
    t_ivl                   r_a, n_a;

    logic                   in_acc;
    logic [CNT_W-1:0]       pos_m1;
    logic [MAX_ENTRIES-1:0] kept_after;
    logic                   is_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign pos_m1     = r_pos - 1'b1;

    // Unmarked entries beyond r_i still to be emitted in the kept pass.
    always_comb begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            kept_after[k] = !r_marks[k] && (CNT_W'(k) > r_i) && (CNT_W'(k) < r_cnt);
        end
        is_last = ~|kept_after;
    end

    always_comb begin
        o_cmp.op = (r_state == S_INS_CMP) ? CMP_GT : CMP_OVL;
        o_cmp.a  = (r_state == S_INS_CMP) ? i_rd_data : r_a;
        o_cmp.b  = (r_state == S_INS_CMP) ? r_new : i_rd_data;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_pos   = r_pos;
        n_marks = r_marks;
        n_ovf   = r_ovf;
        n_new   = r_new;
        n_a     = r_a;

        o_tbl.rd_en   = 1'b0;
        o_tbl.rd_addr = '0;
        o_tbl.we      = 1'b0;
        o_tbl.wr_addr = r_pos[IDX_W-1:0];
        o_tbl.wr_data = r_new;

        o_emit.vld        = 1'b0;
        o_emit.ivl        = i_rd_data;
        o_emit.removed    = 1'b0;
        o_emit.overflowed = r_ovf;
        o_emit.last       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.mode == MODE_INSERT) begin
                        if (r_cnt == CNT_W'(MAX_ENTRIES)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_new   = '{sh: i_in_data.start_hour, sm: i_in_data.start_minute,
                                        eh: i_in_data.end_hour,   em: i_in_data.end_minute};
                            n_pos   = r_cnt;
                            n_state = S_INS_RD;
                        end
                    end else if (r_cnt != '0) begin
                        n_i     = '0;
                        n_state = S_RES_OUTER;
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    o_tbl.we = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_tbl.rd_en   = 1'b1;
                    o_tbl.rd_addr = pos_m1[IDX_W-1:0];
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                o_tbl.we = 1'b1;
                if (i_cmp_hit) begin
                    // Shift the later-starting entry up one slot.
                    o_tbl.wr_data = i_rd_data;
                    n_pos         = pos_m1;
                    n_state       = S_INS_RD;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RES_OUTER: begin
                if (r_i == r_cnt) begin
                    n_i     = '0;
                    n_state = S_KEEP_RD;
                end else if (r_marks[r_i[IDX_W-1:0]]) begin
                    n_i = r_i + 1'b1;
                end else begin
                    o_tbl.rd_en   = 1'b1;
                    o_tbl.rd_addr = r_i[IDX_W-1:0];
                    n_state       = S_RES_LOADA;
                end
            end
            S_RES_LOADA: begin
                n_a     = i_rd_data;
                n_j     = r_i + 1'b1;
                n_state = S_RES_JRD;
            end
            S_RES_JRD: begin
                if (r_j == r_cnt) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RES_OUTER;
                end else if (r_marks[r_j[IDX_W-1:0]]) begin
                    n_j = r_j + 1'b1;
                end else begin
                    o_tbl.rd_en   = 1'b1;
                    o_tbl.rd_addr = r_j[IDX_W-1:0];
                    n_state       = S_RES_JCMP;
                end
            end
            S_RES_JCMP: begin
                if (!i_cmp_hit) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_RES_JRD;
                end else if (i_out_free) begin
                    o_emit.vld                = 1'b1;
                    o_emit.removed            = 1'b1;
                    n_marks[r_j[IDX_W-1:0]]   = 1'b1;
                    n_j                       = r_j + 1'b1;
                    n_state                   = S_RES_JRD;
                end
            end
            S_KEEP_RD: begin
                if (r_i == r_cnt) begin
                    n_cnt   = '0;
                    n_marks = '0;
                    n_state = S_IDLE;
                end else if (r_marks[r_i[IDX_W-1:0]]) begin
                    n_i = r_i + 1'b1;
                end else begin
                    o_tbl.rd_en   = 1'b1;
                    o_tbl.rd_addr = r_i[IDX_W-1:0];
                    n_state       = S_KEEP_EMIT;
                end
            end
            S_KEEP_EMIT: begin
                if (i_out_free) begin
                    o_emit.vld  = 1'b1;
                    o_emit.last = is_last;
                    n_i         = r_i + 1'b1;
                    n_state     = S_KEEP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_pos   <= '0;
            r_marks <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_pos   <= n_pos;
            r_marks <= n_marks;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        r_a   <= n_a;
    end

    `ISOF_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(MAX_ENTRIES), "entry count above table size")
    `ISOF_ASSERT_SAME(a_emit_free, o_emit.vld, i_out_free, "emit while output stage is full")
    `ISOF_ASSERT_SAME(a_idle_marks, r_state == S_IDLE, r_marks == '0, "removal marks left set at idle")
    `ISOF_ASSERT_NEXT(a_ovf_sticky, r_ovf, r_ovf, "overflow flag cleared without reset")
    `ISOF_ASSERT_SAME(a_last_kept, o_emit.vld && o_emit.last, !o_emit.removed, "last beat on a removed entry")

endmodule

// ----- rtl/interval_sort_overlap_filter_top.sv -----
// ============================================================================
// interval_sort_overlap_filter_top
// Sorted interval table with greedy overlap removal and ordered readout.
// ============================================================================
//
//   Channel  Dir  Handshake                  Beat payload
//   -------  ---  -------------------------  ---------------------------------
//   in       in   i_in_valid / o_in_stall    t_in_item: mode, start, end
//   out      out  o_out_valid / i_out_stall  t_out_item: interval, removed,
//                                            overflowed, last
//
// Insert: walks down from the end of the table, reading the entry below; each
//   entry with a later start moves up one slot, and the new entry is written
//   above the first entry with an earlier or equal start, or into slot 0, all
//   through the single table read port; a full table drops it and sets overflow.
// Resolve: each unmarked outer entry is compared for overlap with every later
//   unmarked entry, and each overlapping one is marked and emitted as removed;
//   a kept pass then emits the unmarked entries in order, the last flagged, and
//   clears count and marks. All of it shares the one compare unit and read port.
// Reset clears the count, marks and overflow flag at once; no clearing pass.
// While the output register is full and stalled, the walk holds in place.
// ============================================================================
module interval_sort_overlap_filter_top
    import isof_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_tbl_req  tbl_req;
    t_ivl      rd_data;
    t_cmp_req  cmp_req;
    logic      cmp_hit;
    t_emit     emit;
    logic      out_free;

    logic      r_out_valid;
    t_out_item r_out_data;

    // Output stage can take a new beat when empty or draining this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    isof_table u_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .o_rd_data (rd_data)
    );

    isof_cmp u_cmp (
        .i_req (cmp_req),
        .o_hit (cmp_hit)
    );

    isof_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_tbl      (tbl_req),
        .i_rd_data  (rd_data),
        .o_cmp      (cmp_req),
        .i_cmp_hit  (cmp_hit)
    );

    // Output register: load a beat from the sequencer, drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.vld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.vld) begin
            r_out_data <= '{out_start_hour:   emit.ivl.sh,
                            out_start_minute: emit.ivl.sm,
                            out_end_hour:     emit.ivl.eh,
                            out_end_minute:   emit.ivl.em,
                            removed:          emit.removed,
                            overflowed:       emit.overflowed,
                            last:             emit.last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
